### design/nwss_pkg.sv
// Shared types and constants for the nibble wildcard signature scanner.
package nwss_pkg;

  localparam int SIG_BYTES   = 16;  // signature bytes held in the registers
  localparam int LEN_CFG_W   = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int RES_OFF_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_CARE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

  localparam logic [7:0] NIB_LO = 8'h0F;
  localparam logic [7:0] NIB_HI = 8'hF0;

  typedef struct packed {
    logic [63:0]          pattern_low;
    logic [63:0]          pattern_high;
    logic [31:0]          nibble_care;
    logic [LEN_CFG_W-1:0] pattern_length;
  } cfg_t;

endpackage

### design/nwss_if.sv
// Stream interfaces: input bytes and scan results.
interface nwss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface nwss_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

### design/nibble_wildcard_signature_scan.sv
// Top level of the nibble wildcard signature scanner.
// Usage:
//  - stream: byte words (data_byte, end_of_buffer) with valid/ready. A word
//    is taken at a clock edge with valid and ready both high.
//  - result: one word per buffer at most: found = 1 with the start offset of
//    the leftmost match, or found = 0 (offset 0) on the final byte of a
//    buffer that held no match. Bytes after a match give nothing.
//  - write_enable/write_index/write_data load the pattern registers
//    (0 pattern_low, 1 pattern_high, 2 nibble_care, 3 pattern_length); write
//    them only while no word is in flight.
// Timing: one byte per cycle sustained while result words are taken. A byte
// is registered in the window stage, the masked compare runs on it, and the
// result register is loaded from the compare when that byte advances.
// Stalls: the result register holds a word while result.ready is low; one
// further byte is still taken into the window stage if that stage was empty,
// then stream.ready drops until the result is taken.
// Reset (rst, synchronous): registers return to pattern 0, length 1, no word
// in flight, byte count cleared.
module nibble_wildcard_signature_scan
  import nwss_pkg::*;
#(
  parameter int PATTERN_MAX  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  nwss_in_if.sink               stream,
  nwss_out_if.source            result,
  input  logic                  write_enable,
  input  logic [CFG_IDX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0] write_data
);

  cfg_t                     cfg;
  logic                     accept;
  logic                     advance;
  logic                     held;
  logic                     held_last;
  logic [PATTERN_MAX*8-1:0] window;
  logic [OFFSET_WIDTH-1:0]  count;
  logic                     hit;
  logic [RES_OFF_W-1:0]     offset;
  logic                     already_found;
  logic                     emit_hit;
  logic                     emit_miss;
  logic                     res_load;

  nwss_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  nwss_window #(
    .PATTERN_MAX  (PATTERN_MAX),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (stream.data_byte),
    .last_in   (stream.end_of_buffer),
    .advance   (advance),
    .held      (held),
    .held_last (held_last),
    .window    (window),
    .count     (count)
  );

  nwss_match #(
    .PATTERN_MAX  (PATTERN_MAX),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_match (
    .cfg    (cfg),
    .window (window),
    .count  (count),
    .hit    (hit),
    .offset (offset)
  );

  assign advance      = held && (!result.valid || result.ready);
  assign stream.ready = !held || advance;
  assign accept       = stream.valid && stream.ready;

  assign emit_hit  = hit && !already_found;
  assign emit_miss = held_last && !already_found && !hit;
  assign res_load  = advance && (emit_hit || emit_miss);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid  <= 1'b0;
      already_found <= 1'b0;
    end else begin
      if (res_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (advance) begin
        if (held_last) begin
          already_found <= 1'b0;
        end else if (emit_hit) begin
          already_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.found        <= emit_hit;
      result.match_offset <= emit_hit ? offset : '0;
    end
  end

  a_miss_zero_offset: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.match_offset == '0)
    else $error("miss word carries a non-zero offset");

  a_stall_means_held: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> held && result.valid)
    else $error("input stalled with nothing pending");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !result.valid || result.ready)
    else $error("result register overwritten before it was taken");

  a_found_sets_result: assert property (@(posedge clk) disable iff (rst)
    $rose(already_found) |-> result.valid && result.found)
    else $error("match flag set without a found word");

endmodule

### design/nwss_cfg_regs.sv
// Configuration registers: pattern bytes, nibble care bits and length.
module nwss_cfg_regs
  import nwss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [CFG_IDX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.nibble_care    <= '0;
      cfg.pattern_length <= LEN_CFG_W'(1);
    end else if (write_enable) begin
      unique case (write_index)
        REG_PATTERN_LOW:    cfg.pattern_low    <= write_data;
        REG_PATTERN_HIGH:   cfg.pattern_high   <= write_data;
        REG_NIBBLE_CARE:    cfg.nibble_care    <= write_data[31:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= write_data[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/nwss_window.sv
// Input stage: sliding byte window, saturating byte count and held word.
module nwss_window #(
  parameter int PATTERN_MAX  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     last_in,
  input  logic                     advance,
  output logic                     held,
  output logic                     held_last,
  output logic [PATTERN_MAX*8-1:0] window,
  output logic [OFFSET_WIDTH-1:0]  count
);

  logic                    restart;  // previous word closed its buffer
  logic [OFFSET_WIDTH-1:0] count_base;

  // window contents past the count are never compared, so no clearing needed
  assign count_base = restart ? '0 : count;

  always_ff @(posedge clk) begin
    if (accept) begin
      window[7:0] <= data_byte;
      for (int j = 1; j < PATTERN_MAX; j++) begin
        window[j*8 +: 8] <= window[(j-1)*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      held_last <= 1'b0;
      restart   <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        held      <= 1'b1;
        held_last <= last_in;
        restart   <= last_in;
        if (count_base != '1) begin
          count <= count_base + OFFSET_WIDTH'(1);
        end else begin
          count <= count_base;
        end
      end else if (advance) begin
        held <= 1'b0;
      end
    end
  end

endmodule

### design/nwss_match.sv
// Parallel masked compare of the window against the signature.
module nwss_match
  import nwss_pkg::*;
#(
  parameter int PATTERN_MAX  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  cfg_t                     cfg,
  input  logic [PATTERN_MAX*8-1:0] window,
  input  logic [OFFSET_WIDTH-1:0]  count,
  output logic                     hit,
  output logic [RES_OFF_W-1:0]     offset
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int XW    = (OFFSET_WIDTH > RES_OFF_W) ? OFFSET_WIDTH : RES_OFF_W;

  logic [LEN_W-1:0]       len_eff;
  logic [PATTERN_MAX-1:0] ok;
  logic [XW-1:0]          count_x;
  logic [XW-1:0]          len_x;
  logic [XW-1:0]          diff_x;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (7'(cfg.pattern_length) > 7'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = LEN_W'(cfg.pattern_length);
    end
  end

  // signature byte k lines up with window[len - 1 - k], newest at 0
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_sig
    logic [7:0] sig;
    logic [7:0] msk;
    logic [7:0] sel;

    if (k < 8) begin : g_lo
      assign sig = cfg.pattern_low[k*8 +: 8];
    end else if (k < SIG_BYTES) begin : g_hi
      assign sig = cfg.pattern_high[(k-8)*8 +: 8];
    end else begin : g_none
      assign sig = '0;
    end

    if (k < SIG_BYTES) begin : g_msk
      assign msk = (cfg.nibble_care[2*k] ? NIB_LO : 8'h00)
                 | (cfg.nibble_care[2*k+1] ? NIB_HI : 8'h00);
    end else begin : g_nomsk
      assign msk = '0;  // beyond the register set: wildcard
    end

    always_comb begin
      sel = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (8'(k + j + 1) == 8'(len_eff)) begin
          sel = window[j*8 +: 8];
        end
      end
    end

    assign ok[k] = (8'(k) >= 8'(len_eff)) || (((sel ^ sig) & msk) == 8'h00);
  end

  assign count_x = XW'(count);
  assign len_x   = XW'(len_eff);
  assign diff_x  = count_x - len_x;
  assign hit     = (count_x >= len_x) && (&ok);
  assign offset  = diff_x[RES_OFF_W-1:0];

endmodule
